// ===== sv/launcher_feed_mode_sequencer_top_macros.svh =====
// assertion macros shared by the sequencer rtl
`ifndef LAUNCHER_FEED_MODE_SEQUENCER_TOP_MACROS_SVH
`define LAUNCHER_FEED_MODE_SEQUENCER_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define LFMS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define LFMS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/lfms_pkg.sv =====
package lfms_pkg;

    localparam int FRAC_BITS = 16;
    localparam int ONE_Q     = 1 << FRAC_BITS;

    // thresholds, rounded to nearest step, compared against 33-bit magnitudes
    localparam logic [32:0] T_CAL   = 33'((ONE_Q + 5) / 10);
    localparam logic [32:0] T_WHL   = 33'(ONE_Q / 2);
    localparam logic [32:0] T_STILL = 33'((ONE_Q + 25) / 50);
    localparam logic [32:0] T_HOME  = 33'((ONE_Q + 10) / 20);
    localparam logic signed [31:0] CAL_RATE = 32'(-3 * ONE_Q);

    localparam logic [2:0] M_STOP  = 3'd0;
    localparam logic [2:0] M_SETUP = 3'd1;
    localparam logic [2:0] M_CAL   = 3'd2;
    localparam logic [2:0] M_READY = 3'd3;
    localparam logic [2:0] M_SHOT  = 3'd4;
    localparam logic [2:0] M_WAIT  = 3'd5;
    localparam logic [2:0] M_CONT  = 3'd6;

    localparam logic [1:0] OP_MANUAL = 2'd0;

    localparam logic [1:0] REQ_STOP  = 2'd0;
    localparam logic [1:0] REQ_SETUP = 2'd1;
    localparam logic [1:0] REQ_SHOT  = 2'd2;
    localparam logic [1:0] REQ_CONT  = 2'd3;

    localparam logic CFG_WHEEL_SPEED = 1'b0;
    localparam logic CFG_FEED_RATE   = 1'b1;

    localparam int IN_DATA_W  = 224;
    localparam int IN_USER_W  = 4;
    localparam int OUT_DATA_W = 72;

    typedef struct packed {
        logic [1:0]         operator_mode;
        logic [1:0]         ready_request;
        logic signed [31:0] feed_angle;
        logic signed [31:0] feed_angle_target;
        logic signed [31:0] feed_rate;
        logic signed [31:0] wheel_a_speed;
        logic signed [31:0] wheel_a_target;
        logic signed [31:0] wheel_b_speed;
        logic signed [31:0] wheel_b_target;
    } t_item;

    typedef struct packed {
        logic [2:0]         launcher_mode;
        logic               drive_enable;
        logic signed [31:0] wheel_speed_cmd;
        logic signed [31:0] feed_rate_cmd;
        logic               feed_rate_cmd_valid;
        logic               step_pulse;
    } t_result;

    // magnitude of a - b without wrap
    function automatic logic [32:0] abs_diff(logic signed [31:0] a, logic signed [31:0] b);
        logic signed [32:0] d;
        d = 33'(a) - 33'(b);
        return d[32] ? 33'(-d) : 33'(d);
    endfunction

endpackage

// ===== sv/lfms_in_stage.sv =====
module lfms_in_stage
    import lfms_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [IN_DATA_W-1:0] i_data,
    input  logic [IN_USER_W-1:0] i_user,
    input  logic                 i_advance,
    output logic                 o_valid,
    output t_item                o_item
);

    logic  r_valid;
    logic  n_valid;
    t_item r_item;
    t_item n_item;

    assign o_ready = !r_valid || i_advance;

    always_comb begin
        n_valid = r_valid;
        n_item  = r_item;
        if (o_ready) begin
            n_valid = i_valid;
        end
        if (o_ready && i_valid) begin
            n_item.operator_mode     = i_user[1:0];
            n_item.ready_request     = i_user[3:2];
            n_item.feed_angle        = i_data[31:0];
            n_item.feed_angle_target = i_data[63:32];
            n_item.feed_rate         = i_data[95:64];
            n_item.wheel_a_speed     = i_data[127:96];
            n_item.wheel_a_target    = i_data[159:128];
            n_item.wheel_b_speed     = i_data[191:160];
            n_item.wheel_b_target    = i_data[223:192];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ===== sv/lfms_decide.sv =====
module lfms_decide
    import lfms_pkg::*;
(
    input  logic [2:0]         i_mode,
    input  t_item              i_item,
    input  logic signed [31:0] i_wheel_speed_target,
    input  logic signed [31:0] i_feed_rate_continuous,
    output t_result            o_result
);

    logic [32:0] ang_err;
    logic [32:0] rate;
    logic [32:0] wa_err;
    logic [32:0] wb_err;
    logic        manual;
    logic [2:0]  m;
    logic        pulse;

    assign ang_err = abs_diff(i_item.feed_angle, i_item.feed_angle_target);
    assign rate    = abs_diff(i_item.feed_rate, 32'sd0);
    assign wa_err  = abs_diff(i_item.wheel_a_speed, i_item.wheel_a_target);
    assign wb_err  = abs_diff(i_item.wheel_b_speed, i_item.wheel_b_target);
    assign manual  = (i_item.operator_mode == OP_MANUAL);

    always_comb begin
        m     = i_mode;
        pulse = 1'b0;
        if (!manual || i_item.ready_request == REQ_STOP) begin
            m = M_STOP;
        end else begin
            case (i_mode)
                M_STOP: begin
                    if (i_item.ready_request == REQ_SETUP) m = M_SETUP;
                end
                M_SETUP: begin
                    // ready wins over calibration
                    if (wa_err < T_WHL && wb_err < T_WHL && rate < T_STILL) begin
                        m = M_READY;
                    end else if (ang_err > T_CAL) begin
                        m = M_CAL;
                    end
                end
                M_READY: begin
                    if (i_item.ready_request == REQ_SHOT) begin
                        m = M_SHOT;
                    end else if (i_item.ready_request == REQ_CONT) begin
                        m = M_CONT;
                    end
                end
                M_SHOT: begin
                    pulse = 1'b1;
                    m     = M_WAIT;
                end
                M_WAIT: begin
                    if (ang_err < T_HOME) m = M_SETUP;
                end
                M_CONT: begin
                    if (i_item.ready_request == REQ_SETUP) m = M_SETUP;
                end
                M_CAL: begin
                    if (rate < T_HOME) m = M_SETUP;
                end
                default: begin
                    m = i_mode;
                end
            endcase
        end
    end

    always_comb begin
        o_result                     = '0;
        o_result.launcher_mode       = m;
        o_result.step_pulse          = pulse;
        if (manual && m != M_STOP) begin
            o_result.drive_enable    = 1'b1;
            o_result.wheel_speed_cmd = i_wheel_speed_target;
            case (m)
                M_SETUP, M_READY: begin
                    o_result.feed_rate_cmd_valid = 1'b1;
                end
                M_CONT: begin
                    o_result.feed_rate_cmd_valid = 1'b1;
                    o_result.feed_rate_cmd       = i_feed_rate_continuous;
                end
                M_CAL: begin
                    o_result.feed_rate_cmd_valid = 1'b1;
                    o_result.feed_rate_cmd       = CAL_RATE;
                end
                default: begin
                    o_result.feed_rate_cmd_valid = 1'b0;
                end
            endcase
        end
    end

endmodule

// ===== sv/launcher_feed_mode_sequencer_top.sv =====
// Launcher feed mode sequencer. Each accepted word is one control tick: the
// seven-state launcher mode advances and the wheel, feeder and step commands
// for the new mode come out as one result word. One word is accepted every
// cycle while the result side keeps up; a result is registered once its word
// leaves the input register (the input register loads on acceptance, the
// result register when the output side can take the word). The rate is set
// by the mode register feeding back through the combinational decision
// logic. The user must write configuration registers through the plain
// write port only while no words are in flight; the block does not enforce it.
`include "launcher_feed_mode_sequencer_top_macros.svh"

module launcher_feed_mode_sequencer_top
    import lfms_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // feed_angle, feed_angle_target, feed_rate, wheel_a_speed, wheel_a_target,
    // wheel_b_speed, wheel_b_target
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // operator_mode, ready_request
    input  logic [IN_USER_W-1:0]  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // launcher_mode, drive_enable, wheel_speed_cmd, feed_rate_cmd,
    // feed_rate_cmd_valid, step_pulse, zero pad
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                  i_cfg_wr_en,
    input  logic                  i_cfg_index,
    input  logic [31:0]           i_cfg_wdata
);

    logic               s1_valid;
    t_item              s1_item;
    logic               s1_advance;
    t_result            calc;

    logic [2:0]         r_mode;
    logic signed [31:0] r_wheel_speed_target;
    logic signed [31:0] r_feed_rate_continuous;
    logic               r_out_valid;
    logic               n_out_valid;
    t_result            r_out;

    logic               out_released;
    logic               out_cmd_zero;
    logic               out_pulse;
    logic               pulse_in_wait;
    logic               out_feed;
    logic               mode_in_step;

    assign s1_advance  = s1_valid && (!r_out_valid || m_axis_tready);
    assign n_out_valid = s1_advance || (r_out_valid && !m_axis_tready);

    lfms_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_data    (s_axis_tdata),
        .i_user    (s_axis_tuser),
        .i_advance (s1_advance),
        .o_valid   (s1_valid),
        .o_item    (s1_item)
    );

    lfms_decide u_decide (
        .i_mode                 (r_mode),
        .i_item                 (s1_item),
        .i_wheel_speed_target   (r_wheel_speed_target),
        .i_feed_rate_continuous (r_feed_rate_continuous),
        .o_result               (calc)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode                 <= M_STOP;
            r_wheel_speed_target   <= '0;
            r_feed_rate_continuous <= '0;
            r_out_valid            <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (s1_advance) begin
                r_mode <= calc.launcher_mode;
            end
            if (i_cfg_wr_en && i_cfg_index == CFG_WHEEL_SPEED) begin
                r_wheel_speed_target <= i_cfg_wdata;
            end
            if (i_cfg_wr_en && i_cfg_index == CFG_FEED_RATE) begin
                r_feed_rate_continuous <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_advance) begin
            r_out <= calc;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out.step_pulse, r_out.feed_rate_cmd_valid,
                            r_out.feed_rate_cmd, r_out.wheel_speed_cmd,
                            r_out.drive_enable, r_out.launcher_mode};

    assign out_released  = r_out_valid && !r_out.drive_enable;
    assign out_cmd_zero  = r_out.wheel_speed_cmd == 32'sd0 && r_out.feed_rate_cmd == 32'sd0
                           && !r_out.feed_rate_cmd_valid;
    assign out_pulse     = r_out_valid && r_out.step_pulse;
    assign pulse_in_wait = r_out.launcher_mode == M_WAIT && r_out.drive_enable;
    assign out_feed      = r_out_valid && r_out.feed_rate_cmd_valid;
    assign mode_in_step  = r_mode == r_out.launcher_mode;

    `LFMS_ASSERT_NOW(a_release_zero, out_released, out_cmd_zero, "released drives carry a command")
    `LFMS_ASSERT_NOW(a_pulse_wait, out_pulse, pulse_in_wait, "step pulse outside wait")
    `LFMS_ASSERT_NOW(a_feed_enable, out_feed, r_out.drive_enable, "feeder command, no enable")
    `LFMS_ASSERT_NEXT(a_mode_track, s1_advance, mode_in_step, "mode register out of step")

endmodule
